// File: rtl/hsfd_pkg.sv
// ----------------------------------------------------------------------------
// hsfd_pkg
// shared constants and helpers for the humidity sensor frame decoder
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0]  CRC_INIT     = 8'hFF;
    localparam logic [7:0]  CRC_POLY_RST = 8'h31;

    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [15:0] T_OFFSET = 16'd4500;
    localparam logic [13:0] H_SCALE  = 14'd12500;
    localparam logic [14:0] H_OFFSET = 15'd600;
    localparam logic [14:0] H_TOP    = 15'd10600;
    localparam logic [13:0] H_MAX    = 14'd10000;
    localparam logic [16:0] DIV_K    = 17'd65535;

    localparam int TDATA_W = 64;

    // eight msb-first crc steps over one byte
    function automatic logic [7:0] crc_shift8(input logic [7:0] v, input logic [7:0] poly);
        logic [7:0] x;
        x = v;
        for (int k = 0; k < 8; k++) begin
            if (x[7]) begin
                x = {x[6:0], 1'b0} ^ poly;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return x;
    endfunction

    // floor(p / 65535) for p below 17500 * 65536
    function automatic logic [14:0] div65535(input logic [30:0] p);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = p[30:16];
        r0 = {1'b0, p[15:0]} + {2'b00, q0};
        return (r0 >= DIV_K) ? q0 + 15'd1 : q0;
    endfunction

endpackage

// File: rtl/humidity_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// decodes six-byte sensor responses into scaled readings or a serial number
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel: tdata holds the byte, tuser[0] the frame
// kind (0 measurement, 1 serial number) and tuser[1] the frame start flag.
// The sixth byte of a frame yields one result on m_axis: temperature and
// humidity in hundredths, or the 32-bit serial number, plus crc error flags.
// The crc polynomial is written over the cfg channel, which is always ready.
// One byte is taken every cycle while s_axis_tready is high. Bytes update
// the crc and frame position at once; a frame's result then passes the
// finished frame register, a multiply stage and a scale stage to m_axis.
// When m_axis stalls, the three result registers fill up first; only then
// does s_axis_tready drop, and it comes back as soon as the receiver takes.
// Reset clears the frame position, the result valids and sets the polynomial
// to 0x31; a byte after reset without frame start opens a frame.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // data_byte
    input  logic [1:0]                   s_axis_tuser,   // op, frame_start
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // temperature_centi, humidity_centi, serial_number, first_crc_bad,
    // second_crc_bad, any_crc_bad
    output logic [hsfd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                   m_axis_tuser    // frame_kind
);
    import hsfd_pkg::*;

    typedef enum logic [2:0] {
        POS_B0   = 3'd0,
        POS_B1   = 3'd1,
        POS_B2   = 3'd2,
        POS_B3   = 3'd3,
        POS_B4   = 3'd4,
        POS_B5   = 3'd5,
        POS_IDLE = 3'd6
    } t_pos;

    logic [7:0]  r_poly;
    t_pos        r_pos, n_pos, w_pos_eff;
    logic        r_kind, n_kind;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_w0, n_w0;
    logic        r_bad1, n_bad1;
    logic [7:0]  r_w1_hi, n_w1_hi;
    logic [7:0]  r_w1_lo, n_w1_lo;
    logic        w_done;
    logic        w_bad2;
    logic [7:0]  w_crc_in;

    logic        r_s1_valid;
    logic        r_s1_kind;
    logic [15:0] r_s1_w0;
    logic [15:0] r_s1_w1;
    logic        r_s1_bad1;
    logic        r_s1_bad2;

    logic        r_s2_valid;
    logic        r_s2_kind;
    logic [30:0] r_s2_pt;
    logic [29:0] r_s2_ph;
    logic [31:0] r_s2_serial;
    logic        r_s2_bad1;
    logic        r_s2_bad2;

    logic        r_m_valid;
    logic [TDATA_W-1:0] r_m_tdata;
    logic        r_m_kind;

    logic        w_adv1, w_adv2, w_adv3;
    logic        w_accept;

    logic [14:0] w_qt, w_qh;
    logic [15:0] w_t;
    logic [13:0] w_h;
    logic [14:0] w_temp;
    logic [13:0] w_hum;
    logic [31:0] w_serial;

    assign w_adv3   = !r_m_valid || m_axis_tready;
    assign w_adv2   = !r_s2_valid || w_adv3;
    assign w_adv1   = !r_s1_valid || w_adv2;
    assign s_axis_tready = w_adv1;
    assign w_accept = s_axis_tvalid && w_adv1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= CRC_POLY_RST;
        end else if (i_cfg_valid) begin
            r_poly <= i_cfg_data;
        end
    end

    // frame position and crc tracking
    always_comb begin
        w_pos_eff = s_axis_tuser[1] ? POS_B0 : r_pos;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_crc     = r_crc;
        n_w0      = r_w0;
        n_bad1    = r_bad1;
        n_w1_hi   = r_w1_hi;
        n_w1_lo   = r_w1_lo;
        w_done    = 1'b0;
        w_bad2    = (r_crc != s_axis_tdata);
        w_crc_in  = ((w_pos_eff == POS_B0) || (w_pos_eff == POS_B3)) ? CRC_INIT : r_crc;
        unique case (w_pos_eff)
            POS_B0: begin
                n_kind = s_axis_tuser[0];
                n_crc  = crc_shift8(w_crc_in ^ s_axis_tdata, r_poly);
                n_w0   = {s_axis_tdata, 8'h00};
                n_pos  = POS_B1;
            end
            POS_B1: begin
                n_crc = crc_shift8(w_crc_in ^ s_axis_tdata, r_poly);
                n_w0  = {r_w0[15:8], s_axis_tdata};
                n_pos = POS_B2;
            end
            POS_B2: begin
                n_bad1 = (r_crc != s_axis_tdata);
                n_crc  = CRC_INIT;
                n_pos  = POS_B3;
            end
            POS_B3: begin
                n_crc   = crc_shift8(w_crc_in ^ s_axis_tdata, r_poly);
                n_w1_hi = s_axis_tdata;
                n_pos   = POS_B4;
            end
            POS_B4: begin
                n_crc   = crc_shift8(w_crc_in ^ s_axis_tdata, r_poly);
                n_w1_lo = s_axis_tdata;
                n_pos   = POS_B5;
            end
            POS_B5: begin
                n_crc  = CRC_INIT;
                n_pos  = POS_IDLE;
                w_done = 1'b1;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_B0;
            r_kind <= 1'b0;
            r_crc  <= CRC_INIT;
            r_bad1 <= 1'b0;
        end else if (w_accept) begin
            r_pos  <= n_pos;
            r_kind <= n_kind;
            r_crc  <= n_crc;
            r_bad1 <= n_bad1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_w0    <= n_w0;
            r_w1_hi <= n_w1_hi;
            r_w1_lo <= n_w1_lo;
        end
    end

    // finished frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= w_accept && w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && w_accept && w_done) begin
            r_s1_kind <= r_kind;
            r_s1_w0   <= r_w0;
            r_s1_w1   <= {r_w1_hi, r_w1_lo};
            r_s1_bad1 <= r_bad1;
            r_s1_bad2 <= w_bad2;
        end
    end

    // scale multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_valid) begin
            r_s2_kind   <= r_s1_kind;
            r_s2_pt     <= 31'(T_SCALE) * 31'(r_s1_w0);
            r_s2_ph     <= 30'(H_SCALE) * 30'(r_s1_w1);
            r_s2_serial <= {r_s1_w0, r_s1_w1};
            r_s2_bad1   <= r_s1_bad1;
            r_s2_bad2   <= r_s1_bad2;
        end
    end

    // divide by 65535, offset and clamp
    always_comb begin
        w_qt = div65535(r_s2_pt);
        w_qh = div65535({1'b0, r_s2_ph});
        w_t  = {1'b0, w_qt} - T_OFFSET;
        if (w_qh < H_OFFSET) begin
            w_h = '0;
        end else if (w_qh > H_TOP) begin
            w_h = H_MAX;
        end else begin
            w_h = 14'(w_qh - H_OFFSET);
        end
        if (r_s2_kind) begin
            w_temp   = '0;
            w_hum    = '0;
            w_serial = r_s2_serial;
        end else begin
            w_temp   = w_t[14:0];
            w_hum    = w_h;
            w_serial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv3) begin
            r_m_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_s2_valid) begin
            r_m_kind  <= r_s2_kind;
            r_m_tdata <= {r_s2_bad1 | r_s2_bad2, r_s2_bad2, r_s2_bad1,
                          w_serial, w_hum, w_temp};
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_tdata;
    assign m_axis_tuser[0] = r_m_kind;

endmodule
